### rtl/dtws_pkg.sv
package dtws_pkg;

  // Field and register widths
  localparam int VOLUME_W  = 12;
  localparam int PWM_W     = 12;
  localparam int STEP_W    = 26;
  localparam int CFG_IDX_W = 2;

  // Sine table
  localparam int TABLE_SIZE = 1000;
  localparam int SINE_W     = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = IDX_W + FRAC_W;

  // Mixer arithmetic
  localparam int SUM_W      = SINE_W + 1;
  localparam int PROD_W     = SUM_W + VOLUME_W + 1;
  localparam int SCALE_SH   = 18;
  localparam int PWM_OFFSET = 1200;

  localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W + 1)'(TABLE_SIZE) << FRAC_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_B = CFG_IDX_W'(1);

  typedef logic [VOLUME_W-1:0]       volume_t;
  typedef logic [PWM_W-1:0]          pwm_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [PHASE_W-1:0]        phase_t;
  typedef logic [IDX_W-1:0]          tidx_t;
  typedef logic signed [SINE_W-1:0]  sine_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef sine_t sine_rom_t [TABLE_SIZE];

  typedef enum logic {
    ST_FILL,
    ST_RUN
  } state_t;

  // Read-port addresses handed from the phase unit to the table memory
  typedef struct packed {
    tidx_t addr_a;
    tidx_t addr_b;
  } tbl_rd_t;

  localparam longint unsigned HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam longint unsigned HALF_PI_QUO = HALF_PI_Q62 / TABLE_SIZE;
  localparam longint unsigned HALF_PI_REM = HALF_PI_Q62 % TABLE_SIZE;

  // Taylor divisors (2k)(2k+1) for k = 1..13
  localparam longint unsigned TAYLOR_DIV [13] = '{
    64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
  };

  // (a * b) >> 62, keeping 64 bits
  function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // trunc(32767 * sin(2*pi*i/TABLE_SIZE)), Taylor series in Q62
  function automatic sine_t sine_entry(int unsigned i);
    longint unsigned t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned m;
    logic            neg;
    sine_t           res;
    neg = 1'b0;
    t   = 64'(4 * i);
    if (t >= 64'(2 * TABLE_SIZE)) begin
      neg = 1'b1;
      t   = t - 64'(2 * TABLE_SIZE);
    end
    if (t > 64'(TABLE_SIZE)) begin
      t = 64'(2 * TABLE_SIZE) - t;
    end
    if (t == 64'd0) begin
      m = 64'd0;
    end else if (t == 64'(TABLE_SIZE)) begin
      m = 64'd32767;
    end else begin
      x    = HALF_PI_QUO * t + (HALF_PI_REM * t) / TABLE_SIZE;
      x2   = mul_q62(x, x);
      term = x;
      acc  = x;
      for (int k = 1; k <= 13; k++) begin
        term = mul_q62(term, x2) / TAYLOR_DIV[k - 1];
        if ((k % 2) == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      m = mul_q62(acc, 64'd32767);
    end
    res = m[SINE_W-1:0];
    if (neg) begin
      res = -res;
    end
    return res;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t tbl;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl[i] = sine_entry(i);
    end
    return tbl;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### rtl/dtws_in_if.sv
interface dtws_in_if;
  logic               valid;
  logic               ready;
  dtws_pkg::volume_t  volume;

  modport source (output valid, output volume, input ready);
  modport sink   (input valid, input volume, output ready);
endinterface

### rtl/dtws_out_if.sv
interface dtws_out_if;
  logic            valid;
  logic            ready;
  dtws_pkg::pwm_t  pwm_compare;

  modport source (output valid, output pwm_compare, input ready);
  modport sink   (input valid, input pwm_compare, output ready);
endinterface

### rtl/dtws_cfg_if.sv
interface dtws_cfg_if;
  logic                valid;
  logic                ready;
  dtws_pkg::cfg_idx_t  index;
  dtws_pkg::step_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/dtws_ram.sv
module dtws_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 1000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/dtws_phase.sv
module dtws_phase (
  input  logic               clk,
  input  logic               rst_n,
  dtws_cfg_if.sink           cfg,
  input  logic               advance,
  output dtws_pkg::tbl_rd_t  tbl_rd
);

  dtws_pkg::phase_t step_a_r, step_a_nxt;
  dtws_pkg::phase_t step_b_r, step_b_nxt;
  dtws_pkg::phase_t phase_a_r, phase_a_nxt;
  dtws_pkg::phase_t phase_b_r, phase_b_nxt;
  dtws_pkg::phase_t step_red;
  logic             cfg_wr;
  logic             wr_a;
  logic             wr_b;
  logic             clr;

  // (p + s) mod limit, with p and s both below the limit
  function automatic dtws_pkg::phase_t wrap_add(dtws_pkg::phase_t p, dtws_pkg::phase_t s);
    logic [dtws_pkg::PHASE_W:0] t;
    logic [dtws_pkg::PHASE_W:0] d;
    t = {1'b0, p} + {1'b0, s};
    d = t - dtws_pkg::PHASE_LIMIT;
    return (t >= dtws_pkg::PHASE_LIMIT) ? d[dtws_pkg::PHASE_W-1:0]
                                        : t[dtws_pkg::PHASE_W-1:0];
  endfunction

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign wr_a      = cfg_wr && (cfg.index == dtws_pkg::REG_STEP_A);
  assign wr_b      = cfg_wr && (cfg.index == dtws_pkg::REG_STEP_B);
  assign clr       = (cfg.data == '0);

  // Steps are kept reduced modulo the limit so one wrap per tick suffices
  always_comb begin
    if ({1'b0, cfg.data} >= dtws_pkg::PHASE_LIMIT) begin
      step_red = dtws_pkg::PHASE_W'({1'b0, cfg.data} - dtws_pkg::PHASE_LIMIT);
    end else begin
      step_red = dtws_pkg::PHASE_W'(cfg.data);
    end
  end

  always_comb begin
    step_a_nxt = wr_a ? step_red : step_a_r;
    step_b_nxt = wr_b ? step_red : step_b_r;
    if (advance) begin
      phase_a_nxt = wrap_add(phase_a_r, step_a_r);
      phase_b_nxt = wrap_add(phase_b_r, step_b_r);
    end else begin
      phase_a_nxt = (wr_a && clr) ? '0 : phase_a_r;
      phase_b_nxt = (wr_b && clr) ? '0 : phase_b_r;
    end
  end

  // Table read follows next phase; without advance it reads held entry or entry 0
  assign tbl_rd.addr_a = phase_a_nxt[dtws_pkg::PHASE_W-1:dtws_pkg::FRAC_W];
  assign tbl_rd.addr_b = phase_b_nxt[dtws_pkg::PHASE_W-1:dtws_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_a_r  <= '0;
      step_b_r  <= '0;
      phase_a_r <= '0;
      phase_b_r <= '0;
    end else begin
      step_a_r  <= step_a_nxt;
      step_b_r  <= step_b_nxt;
      phase_a_r <= phase_a_nxt;
      phase_b_r <= phase_b_nxt;
    end
  end

endmodule

### rtl/dtws_mix.sv
module dtws_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  dtws_pkg::volume_t  volume,
  input  dtws_pkg::sine_t    word_a,
  input  dtws_pkg::sine_t    word_b,
  output logic               take_ok,
  dtws_out_if.source         out
);

  logic                         v1_r, v1_nxt;
  logic                         v2_r, v2_nxt;
  logic                         ov_r, ov_nxt;
  dtws_pkg::volume_t            vol1_r;
  dtws_pkg::prod_t              prod_r;
  dtws_pkg::pwm_t               pwm_r;
  logic                         en1;
  logic                         en2;
  logic signed [dtws_pkg::SUM_W-1:0]        sum_s;
  logic signed [dtws_pkg::VOLUME_W:0]       vol_s;
  dtws_pkg::prod_t              prod_nxt;
  dtws_pkg::prod_t              shifted;
  dtws_pkg::pwm_t               pwm_nxt;

  // Each stage moves when the one after it is empty or moving
  assign en2     = !ov_r || out.ready;
  assign en1     = !v2_r || en2;
  assign take_ok = !v1_r || en1;

  assign v1_nxt = take_ok ? in_fire : v1_r;
  assign v2_nxt = en1 ? v1_r : v2_r;
  assign ov_nxt = en2 ? v2_r : ov_r;

  assign sum_s    = dtws_pkg::SUM_W'(word_a) + dtws_pkg::SUM_W'(word_b);
  assign vol_s    = $signed({1'b0, vol1_r});
  assign prod_nxt = sum_s * vol_s;

  // Arithmetic shift gives the floor for negative products
  assign shifted = prod_r >>> dtws_pkg::SCALE_SH;
  assign pwm_nxt = shifted[dtws_pkg::PWM_W-1:0] + dtws_pkg::PWM_W'(dtws_pkg::PWM_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      vol1_r <= volume;
    end
    if (en1 && v1_r) begin
      prod_r <= prod_nxt;
    end
    if (en2 && v2_r) begin
      pwm_r <= pwm_nxt;
    end
  end

  assign out.valid       = ov_r;
  assign out.pwm_compare = pwm_r;

endmodule

### rtl/dual_tone_wavetable_synth_top.sv
// Channel  Dir  Payload                         Transfer
// in_ch    in   volume[11:0]                    valid & ready
// out_ch   out  pwm_compare[11:0]               valid & ready
// cfg_ch   in   index[1:0], data[25:0]          valid & ready (ready always high)
//
// One item per cycle while out_ch is not stalled; a result is offered once its input transaction
// has passed the table read, multiply and scale/offset into the output register.
// After reset the sine memory is loaded with all 1000 entries; in_ch.ready stays low meanwhile.
// A stalled output holds its result while up to two more items enter the pipeline.
// Phase accumulators and steps reset to zero.
module dual_tone_wavetable_synth_top (
  input  logic        clk,
  input  logic        rst_n,
  dtws_in_if.sink     in_ch,
  dtws_out_if.source  out_ch,
  dtws_cfg_if.sink    cfg_ch
);

  dtws_pkg::state_t  state_r, state_nxt;
  dtws_pkg::tidx_t   fill_cnt_r, fill_cnt_nxt;
  logic              fill_we;
  logic              running;
  logic              take_ok;
  logic              in_fire;
  dtws_pkg::tbl_rd_t tbl_rd;
  logic [dtws_pkg::SINE_W-1:0] rd_a;
  logic [dtws_pkg::SINE_W-1:0] rd_b;
  logic              fill_last;

  assign fill_last = (fill_cnt_r == dtws_pkg::IDX_W'(dtws_pkg::TABLE_SIZE - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtws_pkg::ST_FILL: begin
        if (fill_last) begin
          state_nxt = dtws_pkg::ST_RUN;
        end
      end
      dtws_pkg::ST_RUN: begin
        state_nxt = dtws_pkg::ST_RUN;
      end
      default: begin
        state_nxt = dtws_pkg::ST_FILL;
      end
    endcase
  end

  always_comb begin
    fill_we = 1'b0;
    running = 1'b0;
    case (state_r)
      dtws_pkg::ST_FILL: begin
        fill_we = 1'b1;
      end
      dtws_pkg::ST_RUN: begin
        running = 1'b1;
      end
      default: begin
        fill_we = 1'b0;
      end
    endcase
  end

  assign fill_cnt_nxt = fill_we ? fill_cnt_r + 1'b1 : fill_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dtws_pkg::ST_FILL;
      fill_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  assign in_ch.ready = running && take_ok;
  assign in_fire     = in_ch.valid && in_ch.ready;

  dtws_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_ch),
    .advance (in_fire),
    .tbl_rd  (tbl_rd)
  );

  dtws_ram #(
    .WIDTH (dtws_pkg::SINE_W),
    .DEPTH (dtws_pkg::TABLE_SIZE)
  ) u_sine_ram (
    .clk     (clk),
    .we      (fill_we),
    .waddr   (fill_cnt_r),
    .wdata   (dtws_pkg::SINE_ROM[fill_cnt_r]),
    .raddr_a (tbl_rd.addr_a),
    .raddr_b (tbl_rd.addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  dtws_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .volume  (in_ch.volume),
    .word_a  ($signed(rd_a)),
    .word_b  ($signed(rd_b)),
    .take_ok (take_ok),
    .out     (out_ch)
  );

endmodule
